### hw/rtl/ctp_pkg.sv
// shared types and constants for the cartesian to polar converter
package ctp_pkg;

  // guard fraction bits carried through the rotation datapath
  localparam int GUARD_BITS = 8;

  // angle accumulator width: 2^31 is pi, with headroom past +-pi
  localparam int ANGLE_W = 34;

  // gain compensation k = 0.60725293500888 as unsigned q0.32, split in halves
  localparam logic [15:0] GAIN_HI = 16'h9B74;
  localparam logic [15:0] GAIN_LO = 16'hEDA8;

  // pi in accumulator units
  localparam logic signed [ANGLE_W-1:0] ANGLE_PI = 34'sh0_8000_0000;

  // atan(2^-i) with 2^31 = pi, truncated
  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  // how the result of one point is formed
  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_AXIS_POS,
    MODE_AXIS_NEG,
    MODE_ORIGIN
  } mode_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
  } ctl_t;

endpackage

### hw/rtl/ctp_cell.sv
// one vectoring micro-rotation stage of the chain
module ctp_cell #(
  parameter int XW    = 27,
  parameter int STAGE = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [XW-1:0]                  x_in,
  input  logic signed [XW-1:0]                  y_in,
  input  logic signed [ctp_pkg::ANGLE_W-1:0]    z_in,
  output logic                                  valid,
  output logic signed [XW-1:0]                  x_out,
  output logic signed [XW-1:0]                  y_out,
  output logic signed [ctp_pkg::ANGLE_W-1:0]    z_out
);

  localparam int ZW = ctp_pkg::ANGLE_W;
  localparam logic [31:0] ATAN = ctp_pkg::ATAN_TABLE[STAGE % 32];
  localparam logic signed [ZW-1:0] STEP = $signed({{(ZW-32){1'b0}}, ATAN});

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  // floor shifts
  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_comb begin
    if (!y_in[XW-1]) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + STEP;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_out <= x_next;
    y_out <= y_next;
    z_out <= z_next;
  end

endmodule

### hw/rtl/ctp_gain.sv
// gain compensation, angle rounding and special-case result selection
module ctp_gain #(
  parameter int DW = 16,
  parameter int XW = 27
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ctp_pkg::ctl_t                         ctl_in,
  input  logic [DW-1:0]                         ymag_in,
  input  logic signed [XW-1:0]                  x_in,
  input  logic signed [ctp_pkg::ANGLE_W-1:0]    z_in,
  output logic                                  valid,
  output logic [DW-1:0]                         radius,
  output logic signed [DW-1:0]                  angle
);

  localparam int ZW = ctp_pkg::ANGLE_W;
  localparam int UW = XW - 1;
  localparam int PW = UW + 16;
  localparam int TW = PW + 1;
  localparam int RW = TW + 1 - 24;
  localparam int S  = 32 - DW;
  localparam logic [DW-1:0] QUARTER = DW'(1) << (DW - 2);

  logic [UW-1:0]        ux;
  ctp_pkg::ctl_t        ctl1;
  logic [DW-1:0]        ymag1;
  logic [PW-1:0]        p_hi;
  logic [PW-1:0]        p_lo;
  logic signed [ZW-1:0] z1;

  logic [TW-1:0]        lo_rnd;
  logic [TW-1:0]        t;
  logic [TW:0]          t_rnd;
  logic [RW-1:0]        r;
  logic [DW-1:0]        r_sat;
  logic [DW-1:0]        ang_q;
  logic [DW-1:0]        radius_next;
  logic [DW-1:0]        angle_next;

  assign ux = x_in[XW-1] ? '0 : x_in[UW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else begin
      ctl1.valid <= ctl_in.valid;
    end
    ctl1.mode <= ctl_in.mode;
  end

  always_ff @(posedge clk) begin
    ymag1     <= ymag_in;
    p_hi      <= PW'(ux) * PW'(ctp_pkg::GAIN_HI);
    p_lo      <= PW'(ux) * PW'(ctp_pkg::GAIN_LO);
    z1        <= z_in;
  end

  assign lo_rnd = TW'(p_lo) + TW'(17'h08000);
  assign t      = TW'(p_hi) + TW'(lo_rnd >> 16);
  assign t_rnd  = (TW + 1)'(t) + (TW + 1)'(24'h800000);
  assign r      = t_rnd[TW:24];
  assign r_sat  = (r[RW-1:DW] != '0) ? '1 : r[DW-1:0];

  generate
    if (S > 0) begin : g_round
      logic signed [ZW:0] z_add;
      logic signed [ZW:0] z_q;
      assign z_add = {z1[ZW-1], z1} + (ZW + 1)'(64'd1 << (S - 1));
      assign z_q   = z_add >>> S;
      assign ang_q = z_q[DW-1:0];
    end else begin : g_exact
      assign ang_q = z1[DW-1:0];
    end
  endgenerate

  always_comb begin
    case (ctl1.mode)
      ctp_pkg::MODE_NORMAL: begin
        radius_next = r_sat;
        angle_next  = ang_q;
      end
      ctp_pkg::MODE_AXIS_POS: begin
        radius_next = ymag1;
        angle_next  = QUARTER;
      end
      ctp_pkg::MODE_AXIS_NEG: begin
        radius_next = ymag1;
        angle_next  = DW'(0) - QUARTER;
      end
      default: begin
        radius_next = '0;
        angle_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl1.valid;
    end
  end

  always_ff @(posedge clk) begin
    radius <= radius_next;
    angle  <= $signed(angle_next);
  end

endmodule

### hw/rtl/cartesian_to_polar_top.sv
// cartesian to polar converter: fold stage, cordic vectoring chain, gain stage
// Takes one point per clock whenever start is high; busy is always low, so a
// point is never refused. Each point's radius and angle appear on the result
// ports for one cycle with done high, after passing in order through the fold
// register, which loads on the edge that takes the point, then one register
// per micro-rotation cell in the chain, and then two registers in the gain
// stage around its two partial-product multiplies. Points come out in the
// order they went in, one per cycle at most, and the receiver must take each
// result in the cycle it is shown.
// The angle is in binary radians, 2^(DATA_WIDTH-1) meaning pi.
module cartesian_to_polar_top #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] x_coord,
  input  logic signed [DATA_WIDTH-1:0] y_coord,
  output logic                         done,
  output logic [DATA_WIDTH-1:0]        radius,
  output logic signed [DATA_WIDTH-1:0] angle
);

  localparam int DW = DATA_WIDTH;
  localparam int N  = ITERATIONS;
  localparam int G  = ctp_pkg::GUARD_BITS;
  localparam int XW = DW + 11;
  localparam int ZW = ctp_pkg::ANGLE_W;

  logic                 x_neg;
  logic                 y_neg;
  logic                 x_zero;
  logic                 y_zero;
  logic signed [DW:0]   xe;
  logic signed [DW:0]   ye;
  logic signed [DW:0]   xf;
  logic signed [DW:0]   yf;
  logic [DW:0]          yabs;
  logic signed [ZW-1:0] z_fold;
  ctp_pkg::ctl_t        ctl_next;

  logic signed [XW-1:0] cx [0:N];
  logic signed [XW-1:0] cy [0:N];
  logic signed [ZW-1:0] cz [0:N];
  logic                 cv [0:N];
  ctp_pkg::ctl_t        side_ctl  [0:N];
  logic [DW-1:0]        side_ymag [0:N];

  assign busy = 1'b0;

  assign x_neg  = x_coord[DW-1];
  assign y_neg  = y_coord[DW-1];
  assign x_zero = (x_coord == '0);
  assign y_zero = (y_coord == '0);
  assign xe     = {x_coord[DW-1], x_coord};
  assign ye     = {y_coord[DW-1], y_coord};

  // rotate through pi into the right half plane
  assign xf     = x_neg ? -xe : xe;
  assign yf     = x_neg ? -ye : ye;
  assign yabs   = y_neg ? (DW + 1)'(0) - ye : ye;
  assign z_fold = !x_neg ? '0 : (y_neg ? -ctp_pkg::ANGLE_PI : ctp_pkg::ANGLE_PI);

  always_comb begin
    ctl_next.valid = start;
    if (x_zero && y_zero) begin
      ctl_next.mode = ctp_pkg::MODE_ORIGIN;
    end else if (x_zero) begin
      ctl_next.mode = y_neg ? ctp_pkg::MODE_AXIS_NEG : ctp_pkg::MODE_AXIS_POS;
    end else begin
      ctl_next.mode = ctp_pkg::MODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0]             <= 1'b0;
      side_ctl[0].valid <= 1'b0;
    end else begin
      cv[0]             <= start;
      side_ctl[0].valid <= ctl_next.valid;
    end
    side_ctl[0].mode <= ctl_next.mode;
  end

  always_ff @(posedge clk) begin
    cx[0]            <= {{(XW-DW-1-G){xf[DW]}}, xf, {G{1'b0}}};
    cy[0]            <= {{(XW-DW-1-G){yf[DW]}}, yf, {G{1'b0}}};
    cz[0]            <= z_fold;
    side_ymag[0]     <= yabs[DW-1:0];
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_chain
      ctp_cell #(
        .XW    (XW),
        .STAGE (i)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .in_valid (cv[i]),
        .x_in     (cx[i]),
        .y_in     (cy[i]),
        .z_in     (cz[i]),
        .valid    (cv[i+1]),
        .x_out    (cx[i+1]),
        .y_out    (cy[i+1]),
        .z_out    (cz[i+1])
      );

      // sideband travels alongside the cell chain
      always_ff @(posedge clk) begin
        if (rst) begin
          side_ctl[i+1].valid <= 1'b0;
        end else begin
          side_ctl[i+1].valid <= side_ctl[i].valid;
        end
        side_ctl[i+1].mode <= side_ctl[i].mode;
      end

      always_ff @(posedge clk) begin
        side_ymag[i+1]     <= side_ymag[i];
      end
    end
  endgenerate

  ctp_gain #(
    .DW (DW),
    .XW (XW)
  ) u_gain (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (side_ctl[N]),
    .ymag_in (side_ymag[N]),
    .x_in    (cx[N]),
    .z_in    (cz[N]),
    .valid   (done),
    .radius  (radius),
    .angle   (angle)
  );

endmodule
